FILE: design/vcc_pkg.sv
// Shared types, constants and command codes of the videotex cursor controller.
`default_nettype none

package vcc_pkg;

    localparam int SCREEN_COLUMNS = 40;
    localparam int SCREEN_LINES   = 25;

    localparam int LINE_W   = 5;
    localparam int COL_W    = 6;
    localparam int FUNC_W   = 3;
    localparam int SCROLL_W = 3;

    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(SCREEN_LINES - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [LINE_W-1:0] HOME_LINE = LINE_W'(1);
    localparam logic [LINE_W-1:0] STATUS_LINE = '0;

    localparam logic [FUNC_W-1:0] FUNC_LEFT  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RIGHT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_UP    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DOWN  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd4;

    localparam logic signed [SCROLL_W-1:0] SCROLL_NONE = 3'sd0;

    // Register map: byte addresses of the configuration registers.
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_ROLLING_MODE = 3'd0;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic [COL_W-1:0]  target_col;
        logic [LINE_W-1:0] target_line;
        logic              double_height;
        logic              wrap;
        logic [FUNC_W-1:0] func;
    } cmd_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_now;
        logic [COL_W-1:0]  col_now;
        logic [LINE_W-1:0] saved_line;
        logic [COL_W-1:0]  saved_col;
    } cursor_t;

endpackage

`default_nettype wire

FILE: design/vcc_regs.sv
// Configuration register file of the cursor controller behind an APB-style port.
`default_nettype none

module vcc_regs
    import vcc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output logic                   rolling_mode
);

    logic rolling_mode_reg;
    logic rolling_mode_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        rolling_mode_next = rolling_mode_reg;
        if (wr_en && paddr == ADDR_ROLLING_MODE) begin
            rolling_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rolling_mode_reg <= 1'b0;
        end else begin
            rolling_mode_reg <= rolling_mode_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr)
            ADDR_ROLLING_MODE: prdata = {31'd0, rolling_mode_reg};
            default:           prdata = '0;
        endcase
    end

    assign rolling_mode = rolling_mode_reg;

endmodule

`default_nettype wire

FILE: design/vcc_step.sv
// Next cursor position and scroll request for one command.
`default_nettype none

module vcc_step
    import vcc_pkg::*;
(
    input  wire cmd_t                    cmd,
    input  wire cursor_t                 cur,
    input  wire logic                    rolling_mode,
    output cursor_t                      nxt,
    output logic signed [SCROLL_W-1:0]   scroll_lines
);

    logic [LINE_W-1:0]           line;
    logic [COL_W-1:0]            col;
    logic                        do_place;
    logic signed [SCROLL_W-1:0]  step_up;
    logic signed [SCROLL_W-1:0]  step_down;

    // Rolling up past the home line asks for a positive scroll, rolling down past the last line for a negative one.
    assign step_up   = cmd.double_height ? 3'sd2 : 3'sd1;
    assign step_down = cmd.double_height ? -3'sd2 : -3'sd1;

    always_comb begin
        line         = cur.line_now;
        col          = cur.col_now;
        do_place     = 1'b0;
        scroll_lines = SCROLL_NONE;
        case (cmd.func)
            FUNC_LEFT: begin
                if (cur.col_now == '0) begin
                    if (cur.line_now != STATUS_LINE && cmd.wrap) begin
                        do_place = 1'b1;
                        col      = LAST_COL;
                        if (cur.line_now == HOME_LINE) begin
                            if (rolling_mode) begin
                                scroll_lines = step_up;
                            end else begin
                                line = LAST_LINE;
                            end
                        end else begin
                            line = cur.line_now - LINE_W'(1);
                        end
                    end
                end else begin
                    do_place = 1'b1;
                    col      = cur.col_now - COL_W'(1);
                end
            end
            FUNC_RIGHT: begin
                if (cur.col_now >= LAST_COL) begin
                    if (cur.line_now != STATUS_LINE && cmd.wrap) begin
                        do_place = 1'b1;
                        col      = '0;
                        if (cur.line_now >= LAST_LINE) begin
                            if (rolling_mode) begin
                                scroll_lines = step_down;
                            end else begin
                                line = HOME_LINE;
                            end
                        end else begin
                            line = cur.line_now + LINE_W'(1);
                        end
                    end
                end else begin
                    do_place = 1'b1;
                    col      = cur.col_now + COL_W'(1);
                end
            end
            FUNC_UP: begin
                if (cur.line_now != STATUS_LINE) begin
                    do_place = 1'b1;
                    if (cur.line_now == HOME_LINE) begin
                        if (rolling_mode) begin
                            scroll_lines = step_up;
                        end else begin
                            line = LAST_LINE;
                        end
                    end else begin
                        line = cur.line_now - LINE_W'(1);
                    end
                end
            end
            FUNC_DOWN: begin
                do_place = 1'b1;
                if (cur.line_now == STATUS_LINE) begin
                    line = cur.saved_line;
                    col  = cur.saved_col;
                end else if (cur.line_now >= LAST_LINE) begin
                    if (cmd.wrap) begin
                        if (rolling_mode) begin
                            scroll_lines = step_down;
                        end else begin
                            line = HOME_LINE;
                        end
                    end
                end else begin
                    line = cur.line_now + LINE_W'(1);
                end
            end
            FUNC_SET: begin
                do_place = 1'b1;
                line = (cmd.target_line > LAST_LINE) ? LAST_LINE : cmd.target_line;
                col  = (cmd.target_col > LAST_COL) ? LAST_COL : cmd.target_col;
            end
            default: begin
                do_place = 1'b0;
            end
        endcase
    end

    // Any position placed on the main screen becomes the saved position.
    always_comb begin
        nxt = cur;
        if (do_place) begin
            nxt.line_now = line;
            nxt.col_now  = col;
            if (line != STATUS_LINE) begin
                nxt.saved_line = line;
                nxt.saved_col  = col;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/videotex_cursor_controller_core.sv
// Top level of the videotex cursor controller: stream ports, command and result registers.
// Each command word is captured in an input register, resolved against the cursor state by
// one level of compare and increment logic, and its result word is held in an output
// register; the cursor state updates in the same cycle. One command is accepted every cycle
// while the result side keeps taking words. The rolling_mode register sits at byte address 0
// of the APB port and should only be written while no command is in flight.
`default_nettype none

module videotex_cursor_controller_core
    import vcc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // {target_col[15:10], target_line[9:5], double_height[4], wrap[3], func[2:0]}
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // {scroll_lines[13:11], cursor_col[10:5], cursor_line[4:0]}, bits 15:14 zero
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic                        rolling_mode;
    logic                        in_valid_reg;
    cmd_t                        in_cmd_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [M_TDATA_W-1:0]        out_data_reg;
    cursor_t                     cur_reg;
    cursor_t                     cur_next;
    logic signed [SCROLL_W-1:0]  scroll;
    logic                        advance;
    logic                        in_take;

    vcc_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .rolling_mode (rolling_mode)
    );

    vcc_step u_step (
        .cmd          (in_cmd_reg),
        .cur          (cur_reg),
        .rolling_mode (rolling_mode),
        .nxt          (cur_next),
        .scroll_lines (scroll)
    );

    // The command in the input register moves on whenever the output register is free
    // or being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            cur_reg.line_now   <= HOME_LINE;
            cur_reg.col_now    <= '0;
            cur_reg.saved_line <= HOME_LINE;
            cur_reg.saved_col  <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                cur_reg <= cur_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_cmd_reg <= cmd_t'(s_tdata);
        end
        if (advance) begin
            out_data_reg <= {2'b00, scroll, cur_next.col_now, cur_next.line_now};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The cursor never leaves the screen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:0] <= LAST_LINE) && (m_tdata[10:5] <= LAST_COL))
    else $error("cursor result outside the screen");

    // A scroll request leaves the cursor on the first or last main-screen line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[13:11] != 3'd0) |->
            (m_tdata[4:0] == HOME_LINE || m_tdata[4:0] == LAST_LINE))
    else $error("scroll request away from a main-screen edge");

    // The saved position always lies on the main screen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg.saved_line != STATUS_LINE && cur_reg.saved_line <= LAST_LINE)
    else $error("saved position outside the main screen");

    // The cursor state changes only when a command moves to the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(cur_reg))
    else $error("cursor state changed without a command");

endmodule

`default_nettype wire

FILE: sim/tb_videotex_cursor_controller_core.sv
// Self-checking testbench for the videotex cursor controller core, with a cursor predictor.
`timescale 1ns / 1ps

module tb_videotex_cursor_controller_core
    import vcc_pkg::*;
();

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int SETTLE_CYCLES   = 8;

    // Command codes with no function; the block must leave the cursor alone.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    typedef struct {
        logic [LINE_W-1:0]          line;
        logic [COL_W-1:0]           col;
        logic signed [SCROLL_W-1:0] scroll;
    } cursor_report_t;

    typedef struct {
        bit             roll;
        cmd_t           cmd;
        bit             typed;
        cursor_report_t want;
    } plan_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Predicted cursor state and configuration.
    logic [LINE_W-1:0] cur_line = HOME_LINE;
    logic [COL_W-1:0]  cur_col = '0;
    logic [LINE_W-1:0] mem_line = HOME_LINE;
    logic [COL_W-1:0]  mem_col = '0;
    bit                roll_en = 1'b0;

    cursor_report_t pending_reports[$];
    plan_row_t      plan_rows[$];
    int             fail_count = 0;
    int unsigned    cycle_count = 0;
    int             send_gap_pct = 0;
    int             stall_pct = 0;

    videotex_cursor_controller_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("videotex_cursor_controller_core verification failed");
            $finish;
        end
    end

    task automatic report_append(input cursor_report_t r);
        pending_reports.insert(pending_reports.size(), r);
    endtask

    function automatic cursor_report_t report_take();
        cursor_report_t r;
        r = pending_reports[0];
        pending_reports.delete(0);
        return r;
    endfunction

    task automatic step_cursor(input cmd_t c, output cursor_report_t r);
        logic [LINE_W-1:0]          ln;
        logic [COL_W-1:0]           cl;
        logic signed [SCROLL_W-1:0] scr;
        logic signed [SCROLL_W-1:0] rise;
        bit                         moved;
        ln = cur_line;
        cl = cur_col;
        scr = SCROLL_NONE;
        rise = c.double_height ? 3'sd2 : 3'sd1;
        moved = 1'b0;
        case (c.func)
            FUNC_LEFT: begin
                if (cl != '0) begin
                    cl = cl - COL_W'(1);
                    moved = 1'b1;
                end else if (ln != STATUS_LINE && c.wrap) begin
                    if (ln == HOME_LINE) begin
                        if (roll_en) scr = rise;
                        else ln = LAST_LINE;
                    end else begin
                        ln = ln - LINE_W'(1);
                    end
                    cl = LAST_COL;
                    moved = 1'b1;
                end
            end
            FUNC_RIGHT: begin
                if (cl < LAST_COL) begin
                    cl = cl + COL_W'(1);
                    moved = 1'b1;
                end else if (ln != STATUS_LINE && c.wrap) begin
                    if (ln >= LAST_LINE) begin
                        if (roll_en) scr = -rise;
                        else ln = HOME_LINE;
                    end else begin
                        ln = ln + LINE_W'(1);
                    end
                    cl = '0;
                    moved = 1'b1;
                end
            end
            FUNC_UP: begin
                if (ln != STATUS_LINE) begin
                    if (ln == HOME_LINE) begin
                        if (roll_en) scr = rise;
                        else ln = LAST_LINE;
                    end else begin
                        ln = ln - LINE_W'(1);
                    end
                    moved = 1'b1;
                end
            end
            FUNC_DOWN: begin
                // Leaving the status row goes back to the last main-screen position.
                if (ln == STATUS_LINE) begin
                    ln = mem_line;
                    cl = mem_col;
                end else if (ln >= LAST_LINE) begin
                    if (c.wrap) begin
                        if (roll_en) scr = -rise;
                        else ln = HOME_LINE;
                    end
                end else begin
                    ln = ln + LINE_W'(1);
                end
                moved = 1'b1;
            end
            FUNC_SET: begin
                ln = (c.target_line > LAST_LINE) ? LAST_LINE : c.target_line;
                cl = (c.target_col > LAST_COL) ? LAST_COL : c.target_col;
                moved = 1'b1;
            end
            default: ;
        endcase
        if (moved) begin
            cur_line = ln;
            cur_col = cl;
            if (ln != STATUS_LINE) begin
                mem_line = ln;
                mem_col = cl;
            end
        end
        r.line = cur_line;
        r.col = cur_col;
        r.scroll = scr;
    endtask

    task automatic add_row(input bit roll, input logic [FUNC_W-1:0] func, input bit wrap,
                           input bit dbl, input int tline, input int tcol, input bit typed,
                           input int wline, input int wcol, input int wscroll);
        plan_row_t row;
        row.roll = roll;
        row.cmd.func = func;
        row.cmd.wrap = wrap;
        row.cmd.double_height = dbl;
        row.cmd.target_line = LINE_W'(tline);
        row.cmd.target_col = COL_W'(tcol);
        row.typed = typed;
        row.want.line = LINE_W'(wline);
        row.want.col = COL_W'(wcol);
        row.want.scroll = SCROLL_W'(wscroll);
        plan_rows.insert(plan_rows.size(), row);
    endtask

    task automatic issue_cmd(input cmd_t c, input bit typed, input cursor_report_t typed_report);
        cursor_report_t predicted;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        do @(posedge aclk); while (!s_tready);
        step_cursor(c, predicted);
        if (typed) begin
            report_append(typed_report);
        end else begin
            report_append(predicted);
        end
    endtask

    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(input bit is_write, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_rolling(input bit mode);
        logic [31:0] readback;
        apb_access(1'b1, ADDR_ROLLING_MODE, 32'(mode), readback);
        roll_en = mode;
        apb_access(1'b0, ADDR_ROLLING_MODE, '0, readback);
        if (readback !== 32'(mode)) begin
            $display("%0t: rolling_mode readback expected %0d, got %0d", $time, mode, readback);
            fail_count++;
        end
    endtask

    // Result side: random backpressure and a field-by-field check of every word taken.
    always @(posedge aclk) begin
        cursor_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = report_take();
                if (m_tdata[4:0] !== want.line) begin
                    $display("%0t: cursor_line expected %0d, got %0d",
                             $time, want.line, m_tdata[4:0]);
                    fail_count++;
                end
                if (m_tdata[10:5] !== want.col) begin
                    $display("%0t: cursor_col expected %0d, got %0d",
                             $time, want.col, m_tdata[10:5]);
                    fail_count++;
                end
                if (m_tdata[13:11] !== want.scroll) begin
                    $display("%0t: scroll_lines expected %0d, got %0d",
                             $time, want.scroll, $signed(m_tdata[13:11]));
                    fail_count++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        cmd_t           c;
        int             pick;
        cursor_report_t no_report;

        // Wrapping mode first: edges, saturation, the status row and spare codes.
        add_row(0, FUNC_LEFT,      0, 0,  0,  0, 1,  1,  0,  0);
        add_row(0, FUNC_UP,        0, 0,  0,  0, 1, 24,  0,  0);
        add_row(0, FUNC_DOWN,      0, 0,  0,  0, 1, 24,  0,  0);
        add_row(0, FUNC_DOWN,      1, 0,  0,  0, 1,  1,  0,  0);
        add_row(0, FUNC_LEFT,      1, 0,  0,  0, 1, 24, 39,  0);
        add_row(0, FUNC_RIGHT,     1, 0,  0,  0, 1,  1,  0,  0);
        add_row(0, FUNC_SET,       0, 0, 31, 63, 1, 24, 39,  0);
        add_row(0, FUNC_RIGHT,     0, 0,  0,  0, 1, 24, 39,  0);
        add_row(0, FUNC_SET,       0, 0,  0, 63, 1,  0, 39,  0);
        add_row(0, FUNC_RIGHT,     1, 0,  0,  0, 1,  0, 39,  0);
        add_row(0, FUNC_SET,       0, 0,  0,  0, 1,  0,  0,  0);
        add_row(0, FUNC_LEFT,      1, 0,  0,  0, 1,  0,  0,  0);
        add_row(0, FUNC_UP,        1, 1,  0,  0, 1,  0,  0,  0);
        add_row(0, FUNC_DOWN,      0, 0,  0,  0, 1, 24, 39,  0);
        add_row(0, FUNC_SPARE_LO,  0, 0,  0,  0, 0,  0,  0,  0);
        add_row(0, FUNC_SPARE_HI,  1, 1, 31, 63, 0,  0,  0,  0);
        // Rolling mode: scroll requests of one and two lines in both directions.
        add_row(1, FUNC_SET,       0, 0,  1,  5, 0,  0,  0,  0);
        add_row(1, FUNC_UP,        0, 0,  0,  0, 1,  1,  5,  1);
        add_row(1, FUNC_UP,        0, 1,  0,  0, 1,  1,  5,  2);
        add_row(1, FUNC_SET,       0, 0,  1,  0, 1,  1,  0,  0);
        add_row(1, FUNC_LEFT,      1, 1,  0,  0, 1,  1, 39,  2);
        add_row(1, FUNC_SET,       0, 0, 24, 39, 1, 24, 39,  0);
        add_row(1, FUNC_RIGHT,     1, 1,  0,  0, 1, 24,  0, -2);
        add_row(1, FUNC_DOWN,      1, 0,  0,  0, 1, 24,  0, -1);
        add_row(1, FUNC_DOWN,      0, 1,  0,  0, 1, 24,  0,  0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan_rows[i]) begin
            if (plan_rows[i].roll != roll_en) begin
                drain_reports();
                program_rolling(plan_rows[i].roll);
            end
            issue_cmd(plan_rows[i].cmd, plan_rows[i].typed, plan_rows[i].want);
        end

        for (int phase = 0; phase < 4; phase++) begin
            send_gap_pct = (phase == 1) ? 52 : (phase == 3) ? 35 : 0;
            stall_pct = (phase == 2) ? 52 : (phase == 3) ? 35 : 0;
            drain_reports();
            program_rolling(phase[0]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    c.func = FUNC_SET;
                else if (pick < 90)
                    c.func = FUNC_W'($urandom_range(FUNC_LEFT, FUNC_DOWN));
                else
                    c.func = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
                c.wrap = ($urandom_range(0, 9) < 7);
                c.double_height = 1'($urandom_range(0, 1));
                // Half of the targets sit near the screen edges so moves keep hitting them.
                if ($urandom_range(0, 1))
                    c.target_line = LINE_W'($urandom_range(0, 31));
                else if ($urandom_range(0, 1))
                    c.target_line = LINE_W'($urandom_range(0, 2));
                else
                    c.target_line = LINE_W'($urandom_range(23, 31));
                if ($urandom_range(0, 1))
                    c.target_col = COL_W'($urandom_range(0, 63));
                else if ($urandom_range(0, 1))
                    c.target_col = COL_W'($urandom_range(0, 1));
                else
                    c.target_col = COL_W'($urandom_range(37, 63));
                issue_cmd(c, 1'b0, no_report);
            end
        end

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("videotex_cursor_controller_core verification clean");
        end else begin
            $display("videotex_cursor_controller_core verification failed");
        end
        $finish;
    end

endmodule
